// ----- rtl/fgks_pkg.sv -----
// Shared types and constants for the functional-graph k-th successor block.
`timescale 1ns / 1ps

package fgks_pkg;

    // Fixed field widths
    localparam int NODE_W   = 10;
    localparam int LABEL_W  = 32;
    localparam int NCOUNT_W = 11;
    localparam int STEP_W   = 60;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 64;

    // Item action codes
    localparam logic ACT_WRITE = 1'b0;

    // Register select (address bit 3)
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_STEP_COUNT = 1'b1;

    // Lift memory read address sources
    localparam logic [1:0] SEL_RB_SELF = 2'd0;
    localparam logic [1:0] SEL_RB_NEXT = 2'd1;
    localparam logic [1:0] SEL_WALK    = 2'd2;

    typedef struct packed {
        logic               action;
        logic [NODE_W-1:0]  node_index;
        logic [NODE_W-1:0]  successor;
        logic [LABEL_W-1:0] label_value;
    } req_t;

    typedef struct packed {
        logic [LABEL_W-1:0] end_label;
        logic [NODE_W-1:0]  end_node;
        logic               bad_index;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       item_wr;
        logic       load_start;
        logic       rb_init;
        logic       tmp_load;
        logic       rb_wr;
        logic       wk_init;
        logic       wk_cap;
        logic       lvl_inc;
        logic       lift_rd;
        logic [1:0] lift_sel;
        logic       label_rd;
        logic       out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic idx_ok;
        logic cur_ok;
        logic step_bit;
        logic lvl_end;
        logic u_last;
        logic t_last;
        logic rsp_full;
    } sts_t;

endpackage

// ----- rtl/fgks_cfg.sv -----
// APB register file holding node_count and step_count.
`timescale 1ns / 1ps

module fgks_cfg #(
    parameter int MAX_NODES = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fgks_pkg::APB_AW-1:0]          paddr,
    input  logic [fgks_pkg::APB_DW-1:0]          pwdata,
    output logic [fgks_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready,
    output logic [$clog2(MAX_NODES+1)-1:0]       eff_count,
    output logic [fgks_pkg::STEP_W-1:0]          step_count,
    output logic                                 cnt_wr
);

    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int CW  = (NCW > fgks_pkg::NCOUNT_W) ? NCW : fgks_pkg::NCOUNT_W;

    logic [fgks_pkg::NCOUNT_W-1:0] node_count_reg;
    logic [fgks_pkg::NCOUNT_W-1:0] node_count_next;
    logic [NCW-1:0]                eff_count_reg;
    logic [NCW-1:0]                eff_count_next;
    logic [fgks_pkg::STEP_W-1:0]   step_count_reg;
    logic [fgks_pkg::STEP_W-1:0]   step_count_next;
    logic                          wr_en;
    logic [fgks_pkg::NCOUNT_W-1:0] wr_count;

    assign wr_en    = psel & penable & pwrite;
    assign wr_count = pwdata[fgks_pkg::NCOUNT_W-1:0];
    assign pready   = 1'b1;

    // Decode writes; saturate the effective count at the table size
    always_comb
    begin
        node_count_next = node_count_reg;
        eff_count_next  = eff_count_reg;
        step_count_next = step_count_reg;
        cnt_wr          = 1'b0;
        if (wr_en)
        begin
            case (paddr[3])
                fgks_pkg::REG_NODE_COUNT:
                begin
                    node_count_next = wr_count;
                    cnt_wr          = 1'b1;
                    if (CW'(wr_count) > CW'(MAX_NODES))
                        eff_count_next = NCW'(MAX_NODES);
                    else
                        eff_count_next = NCW'(wr_count);
                end
                fgks_pkg::REG_STEP_COUNT:
                    step_count_next = pwdata[fgks_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= fgks_pkg::NCOUNT_W'(1);
            eff_count_reg  <= NCW'(1);
            step_count_reg <= '0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            eff_count_reg  <= eff_count_next;
            step_count_reg <= step_count_next;
        end
    end

    // Read back
    always_comb
    begin
        case (paddr[3])
            fgks_pkg::REG_NODE_COUNT: prdata = fgks_pkg::APB_DW'(node_count_reg);
            fgks_pkg::REG_STEP_COUNT: prdata = fgks_pkg::APB_DW'(step_count_reg);
            default:                  prdata = '0;
        endcase
    end

    assign eff_count  = eff_count_reg;
    assign step_count = step_count_reg;

endmodule

// ----- rtl/fgks_dp.sv -----
// Datapath: lift and label memories, walk and rebuild counters, result register.
`timescale 1ns / 1ps

module fgks_dp #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 60
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fgks_pkg::req_t                   req,
    input  logic [$clog2(MAX_NODES+1)-1:0]   eff_count,
    input  logic [fgks_pkg::STEP_W-1:0]      step_count,
    input  fgks_pkg::cmd_t                   cmd,
    output fgks_pkg::sts_t                   sts,
    output fgks_pkg::rsp_t                   rsp,
    output logic                             rsp_valid,
    input  logic                             rsp_ready
);

    localparam int NAW    = $clog2(MAX_NODES);
    localparam int LVW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LCW    = $clog2(LEVELS + 1);
    localparam int NCW    = $clog2(MAX_NODES + 1);
    localparam int CMPW   = (NCW > fgks_pkg::NODE_W) ? NCW : fgks_pkg::NODE_W;
    localparam int LDEPTH = 2 ** (LVW + NAW);

    // Lift memory is level-major: address = {level, node}
    logic [fgks_pkg::NODE_W-1:0]  lift_mem [LDEPTH];
    logic [fgks_pkg::LABEL_W-1:0] label_mem [MAX_NODES];

    logic [fgks_pkg::NODE_W-1:0]  lift_rd_reg;
    logic [fgks_pkg::LABEL_W-1:0] label_rd_reg;
    logic [fgks_pkg::NODE_W-1:0]  cur_reg, cur_next;
    logic [fgks_pkg::NODE_W-1:0]  tmp_reg, tmp_next;
    logic [NAW-1:0]               u_reg, u_next;
    logic [LVW-1:0]               t_reg, t_next;
    logic [LCW-1:0]               lvl_reg, lvl_next;
    fgks_pkg::rsp_t               rsp_reg, rsp_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    logic [LVW+NAW-1:0]           lift_ra;
    logic [LVW+NAW-1:0]           lift_wa;
    logic [fgks_pkg::NODE_W-1:0]  lift_wd;
    logic                         lift_we;
    logic [LVW-1:0]               t_prev;
    logic [LEVELS-1:0]            step_ext;
    logic                         tmp_ok;
    logic [CMPW-1:0]              nc_cmp;

    assign nc_cmp   = CMPW'(eff_count);
    assign t_prev   = t_reg - 1'b1;
    assign step_ext = LEVELS'(step_count);
    assign tmp_ok   = CMPW'(tmp_reg) < nc_cmp;

    // Status toward the controller
    assign sts.idx_ok   = CMPW'(req.node_index) < CMPW'(MAX_NODES);
    assign sts.cur_ok   = CMPW'(cur_reg) < nc_cmp;
    assign sts.step_bit = step_ext[LVW'(lvl_reg)];
    assign sts.lvl_end  = lvl_reg == LCW'(LEVELS);
    assign sts.u_last   = CMPW'(u_reg) == nc_cmp - CMPW'(1);
    assign sts.t_last   = t_reg == LVW'(LEVELS - 1);
    assign sts.rsp_full = rsp_valid_reg;

    // Lift read address
    always_comb
    begin
        case (cmd.lift_sel)
            fgks_pkg::SEL_RB_SELF: lift_ra = {t_prev, u_reg};
            fgks_pkg::SEL_RB_NEXT: lift_ra = {t_prev, NAW'(lift_rd_reg)};
            fgks_pkg::SEL_WALK:    lift_ra = {LVW'(lvl_reg), NAW'(cur_reg)};
            default:               lift_ra = {LVW'(lvl_reg), NAW'(cur_reg)};
        endcase
    end

    // Lift write: level 0 from a write beat, higher levels from the rebuild
    always_comb
    begin
        lift_we = cmd.item_wr | cmd.rb_wr;
        if (cmd.item_wr)
        begin
            lift_wa = {LVW'(0), NAW'(req.node_index)};
            lift_wd = req.successor;
        end
        else
        begin
            lift_wa = {t_reg, u_reg};
            lift_wd = tmp_ok ? lift_rd_reg : tmp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lift_we)
            lift_mem[lift_wa] <= lift_wd;
        if (cmd.lift_rd)
            lift_rd_reg <= lift_mem[lift_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_wr)
            label_mem[NAW'(req.node_index)] <= req.label_value;
        if (cmd.label_rd)
            label_rd_reg <= label_mem[NAW'(cur_reg)];
    end

    // Walk position, rebuild cursor and level counters
    always_comb
    begin
        cur_next = cur_reg;
        tmp_next = tmp_reg;
        u_next   = u_reg;
        t_next   = t_reg;
        lvl_next = lvl_reg;
        if (cmd.load_start)
            cur_next = req.node_index;
        else if (cmd.wk_cap)
            cur_next = lift_rd_reg;
        if (cmd.tmp_load)
            tmp_next = lift_rd_reg;
        if (cmd.rb_init)
        begin
            u_next = '0;
            t_next = LVW'(1);
        end
        else if (cmd.rb_wr)
        begin
            if (sts.u_last)
            begin
                u_next = '0;
                t_next = t_reg + 1'b1;
            end
            else
                u_next = u_reg + 1'b1;
        end
        if (cmd.wk_init)
            lvl_next = '0;
        else if (cmd.lvl_inc)
            lvl_next = lvl_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        tmp_reg <= tmp_next;
        u_reg   <= u_next;
        t_reg   <= t_next;
        lvl_reg <= lvl_next;
        rsp_reg <= rsp_next;
    end

    // Result register: load on finish, drop on output beat
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (cmd.out_load)
        begin
            rsp_next.end_label = sts.cur_ok ? label_rd_reg : '0;
            rsp_next.end_node  = cur_reg;
            rsp_next.bad_index = ~sts.cur_ok;
            rsp_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- rtl/fgks_ctrl.sv -----
// Controller: sequences writes, table rebuild, the lifting walk and the result.
`timescale 1ns / 1ps

module fgks_ctrl #(
    parameter int LEVELS = 60
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_action,
    output logic           req_ready,
    input  logic           rsp_ready,
    input  logic           cnt_wr,
    input  fgks_pkg::sts_t sts,
    output fgks_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_START  = 4'd1;
    localparam logic [3:0] ST_RB_A   = 4'd2;
    localparam logic [3:0] ST_RB_B   = 4'd3;
    localparam logic [3:0] ST_RB_C   = 4'd4;
    localparam logic [3:0] ST_WALK   = 4'd5;
    localparam logic [3:0] ST_WK_CAP = 4'd6;
    localparam logic [3:0] ST_LABEL  = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       fresh_reg, fresh_next;

    assign req_ready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        fresh_next = fresh_reg;
        cmd        = '0;
        cmd.lift_sel = fgks_pkg::SEL_WALK;
        case (state_reg)
            // Take a beat: store a node entry, or start a query
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_action == fgks_pkg::ACT_WRITE)
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.item_wr = 1'b1;
                            fresh_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        cmd.load_start = 1'b1;
                        state_next     = ST_START;
                    end
                end
            end
            // Bad start goes straight out; stale table is rebuilt first
            ST_START:
            begin
                if (!sts.cur_ok)
                    state_next = ST_FIN;
                else if (LEVELS > 1 && !fresh_reg)
                begin
                    cmd.rb_init = 1'b1;
                    state_next  = ST_RB_A;
                end
                else
                begin
                    fresh_next  = 1'b1;
                    cmd.wk_init = 1'b1;
                    state_next  = ST_WALK;
                end
            end
            // Rebuild: read v = up[t-1][u]
            ST_RB_A:
            begin
                cmd.lift_rd  = 1'b1;
                cmd.lift_sel = fgks_pkg::SEL_RB_SELF;
                state_next   = ST_RB_B;
            end
            // Rebuild: hold v, read up[t-1][v]
            ST_RB_B:
            begin
                cmd.lift_rd  = 1'b1;
                cmd.lift_sel = fgks_pkg::SEL_RB_NEXT;
                cmd.tmp_load = 1'b1;
                state_next   = ST_RB_C;
            end
            // Rebuild: write up[t][u], advance node then level
            ST_RB_C:
            begin
                cmd.rb_wr = 1'b1;
                if (sts.u_last && sts.t_last)
                begin
                    fresh_next  = 1'b1;
                    cmd.wk_init = 1'b1;
                    state_next  = ST_WALK;
                end
                else
                    state_next = ST_RB_A;
            end
            // Walk: follow one level per set step bit
            ST_WALK:
            begin
                if (sts.lvl_end)
                    state_next = ST_LABEL;
                else if (sts.step_bit && sts.cur_ok)
                begin
                    cmd.lift_rd = 1'b1;
                    state_next  = ST_WK_CAP;
                end
                else
                    cmd.lvl_inc = 1'b1;
            end
            ST_WK_CAP:
            begin
                cmd.wk_cap  = 1'b1;
                cmd.lvl_inc = 1'b1;
                state_next  = ST_WALK;
            end
            ST_LABEL:
            begin
                cmd.label_rd = 1'b1;
                state_next   = ST_FIN;
            end
            // Hand the result to the output register once it has room
            ST_FIN:
            begin
                if (!sts.rsp_full || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (cnt_wr)
            fresh_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fresh_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

// ----- rtl/functional_graph_kth_successor.sv -----
// Top level of the functional-graph k-th successor block: config, controller, datapath.
`timescale 1ns / 1ps

// Write beats (action 0) store one node's successor and label and mark the
// lifting table stale, as does a write to node_count. A query beat
// (action 1) walks from its start node step_count steps using a table of
// LEVELS levels, one level per set bit of step_count, and returns one result
// beat with the reached node's label. The walk uses the single read port of
// the lift memory level by level. The first query with an in-range start node
// after the table goes stale first rebuilds it, each entry needing two
// dependent reads and one write of that memory. A query whose start node is
// at or above node_count skips both rebuild and walk. A finished result sits
// in an output register, so the next beat is taken while it waits.

module functional_graph_kth_successor #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 60
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fgks_pkg::APB_AW-1:0] paddr,
    input  logic [fgks_pkg::APB_DW-1:0] pwdata,
    output logic [fgks_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  fgks_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output fgks_pkg::rsp_t              rsp
);

    localparam int NCW = $clog2(MAX_NODES + 1);

    logic [NCW-1:0]              eff_count;
    logic [fgks_pkg::STEP_W-1:0] step_count;
    logic                        cnt_wr;
    fgks_pkg::cmd_t              cmd;
    fgks_pkg::sts_t              sts;

    fgks_cfg #(
        .MAX_NODES (MAX_NODES)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .eff_count  (eff_count),
        .step_count (step_count),
        .cnt_wr     (cnt_wr)
    );

    fgks_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req.action),
        .req_ready  (req_ready),
        .rsp_ready  (rsp_ready),
        .cnt_wr     (cnt_wr),
        .sts        (sts),
        .cmd        (cmd)
    );

    fgks_dp #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .eff_count  (eff_count),
        .step_count (step_count),
        .cmd        (cmd),
        .sts        (sts),
        .rsp        (rsp),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready)
    );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the functional-graph k-th successor block.
`timescale 1ns / 1ps

module tb_top;

    localparam int     N_NODES      = 1024;
    localparam int     N_LEVELS     = 60;
    localparam int     CLK_HALF     = 10;
    localparam int     RESET_CYCLES = 8;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     RANDOM_BEATS = 300;
    localparam longint CYCLE_LIMIT  = 5000000;

    localparam logic ACT_QUERY = ~fgks_pkg::ACT_WRITE;
    localparam logic [fgks_pkg::APB_AW-1:0] ADDR_NODE_COUNT = {fgks_pkg::REG_NODE_COUNT, 3'b000};
    localparam logic [fgks_pkg::APB_AW-1:0] ADDR_STEP_COUNT = {fgks_pkg::REG_STEP_COUNT, 3'b000};
    localparam logic [63:0] STEP_MASK  =
        {{(64-fgks_pkg::STEP_W){1'b0}}, {fgks_pkg::STEP_W{1'b1}}};
    localparam logic [63:0] NCOUNT_MAX =
        {{(64-fgks_pkg::NCOUNT_W){1'b0}}, {fgks_pkg::NCOUNT_W{1'b1}}};

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [fgks_pkg::APB_AW-1:0] paddr     = '0;
    logic [fgks_pkg::APB_DW-1:0] pwdata    = '0;
    logic [fgks_pkg::APB_DW-1:0] prdata;
    logic                        pready;
    logic                        req_valid = 1'b0;
    logic                        req_ready;
    fgks_pkg::req_t              req       = '0;
    logic                        rsp_valid;
    logic                        rsp_ready = 1'b0;
    fgks_pkg::rsp_t              rsp;

    // Mirror of the block state used to work out each end node
    logic [fgks_pkg::NODE_W-1:0]   hop_tbl [N_NODES][N_LEVELS];
    logic [fgks_pkg::LABEL_W-1:0]  node_label [N_NODES];
    bit                            node_written [N_NODES];
    bit                            hops_fresh = 1'b0;
    logic [fgks_pkg::NCOUNT_W-1:0] cfg_nodes  = 1;
    logic [fgks_pkg::STEP_W-1:0]   cfg_steps  = '0;

    fgks_pkg::rsp_t ends_due [$];
    fgks_pkg::rsp_t end_want;
    int             mismatches    = 0;
    int             beats_sent    = 0;
    int             send_idle_pct = 16;
    int             recv_idle_pct = 69;
    longint         cycle_count   = 0;

    functional_graph_kth_successor #(
        .MAX_NODES(N_NODES),
        .LEVELS   (N_LEVELS)
    ) dut (.*);

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("functional_graph_kth_successor: mismatch");
            $finish;
        end
    end

    // Check each result beat against the oldest expected end, then randomize ready
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (ends_due.size() == 0)
            begin
                $error("result beat with nothing expected: node %0d", rsp.end_node);
                mismatches++;
            end
            else
            begin
                end_want = ends_due.pop_front();
                if (rsp.end_label !== end_want.end_label)
                begin
                    $error("end_label: expected %h, got %h", end_want.end_label, rsp.end_label);
                    mismatches++;
                end
                if (rsp.end_node !== end_want.end_node)
                begin
                    $error("end_node: expected %0d, got %0d", end_want.end_node, rsp.end_node);
                    mismatches++;
                end
                if (rsp.bad_index !== end_want.bad_index)
                begin
                    $error("bad_index: expected %0b, got %0b",
                           end_want.bad_index, rsp.bad_index);
                    mismatches++;
                end
            end
        end
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int unsigned live_nodes();
        return (cfg_nodes > N_NODES) ? N_NODES : cfg_nodes;
    endfunction

    // Apply one accepted beat to the mirror; queries queue their expected end
    function automatic void predict_end(fgks_pkg::req_t item);
        int unsigned    nc;
        int unsigned    v;
        int unsigned    w;
        fgks_pkg::rsp_t r;
        nc = live_nodes();
        if (item.action == fgks_pkg::ACT_WRITE)
        begin
            hop_tbl[item.node_index][0]   = item.successor;
            node_label[item.node_index]   = item.label_value;
            node_written[item.node_index] = 1'b1;
            hops_fresh = 1'b0;
            return;
        end
        v = item.node_index;
        if (v < nc && !hops_fresh)
        begin
            // Rebuild: level t is level t-1 taken twice, out-of-range nodes absorb
            for (int t = 1; t < N_LEVELS; t++)
            begin
                for (int unsigned u = 0; u < nc; u++)
                begin
                    w = hop_tbl[u][t-1];
                    hop_tbl[u][t] = (w < nc) ? hop_tbl[w][t-1] : fgks_pkg::NODE_W'(w);
                end
            end
            hops_fresh = 1'b1;
        end
        // Walk one level per set step bit
        if (v < nc)
        begin
            for (int i = 0; i < N_LEVELS; i++)
            begin
                if (cfg_steps[i] && v < nc)
                    v = hop_tbl[v][i];
            end
        end
        r.end_node = fgks_pkg::NODE_W'(v);
        if (v < nc)
        begin
            r.end_label = node_label[v];
            r.bad_index = 1'b0;
        end
        else
        begin
            r.end_label = '0;
            r.bad_index = 1'b1;
        end
        ends_due.push_back(r);
    endfunction

    function automatic logic [fgks_pkg::NODE_W-1:0] pick_node(int unsigned nc,
                                                              int unsigned in_pct);
        if (nc > 0 && $urandom_range(99) < in_pct)
            return fgks_pkg::NODE_W'($urandom_range(nc - 1));
        return fgks_pkg::NODE_W'($urandom_range(N_NODES - 1));
    endfunction

    // Present one beat, hold it until accepted, then predict it
    task automatic send_item(fgks_pkg::req_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_end(item);
        beats_sent++;
    endtask

    task automatic write_node(logic [fgks_pkg::NODE_W-1:0] node,
                              logic [fgks_pkg::NODE_W-1:0] next,
                              logic [fgks_pkg::LABEL_W-1:0] label);
        fgks_pkg::req_t item;
        item.action      = fgks_pkg::ACT_WRITE;
        item.node_index  = node;
        item.successor   = next;
        item.label_value = label;
        send_item(item);
    endtask

    task automatic query_node(logic [fgks_pkg::NODE_W-1:0] start);
        fgks_pkg::req_t item;
        item.action      = ACT_QUERY;
        item.node_index  = start;
        // Unused on queries; keep them noisy
        item.successor   = fgks_pkg::NODE_W'($urandom);
        item.label_value = $urandom;
        send_item(item);
    endtask

    // Drop valid and hold off until every expected end has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (ends_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [fgks_pkg::APB_AW-1:0] addr,
                             logic [fgks_pkg::APB_DW-1:0] data);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_NODE_COUNT)
        begin
            cfg_nodes  = data[fgks_pkg::NCOUNT_W-1:0];
            hops_fresh = 1'b0;
        end
        else
            cfg_steps = data[fgks_pkg::STEP_W-1:0];
    endtask

    // Write every node in range that has no entry yet
    task automatic fill_unwritten(int unsigned in_pct);
        int unsigned nc;
        nc = live_nodes();
        for (int unsigned n = 0; n < nc; n++)
        begin
            if (!node_written[n])
                write_node(fgks_pkg::NODE_W'(n), pick_node(nc, in_pct), $urandom);
        end
    endtask

    // After reset only node 0 is in range and nothing is written
    task automatic test_reset_state();
        query_node(1);
        query_node(fgks_pkg::NODE_W'(N_NODES - 1));
    endtask

    task automatic test_no_nodes();
        write_reg(ADDR_NODE_COUNT, 0);
        query_node(0);
        query_node(10'h2AA);
    endtask

    // Small cycle 0->1->2->0 plus node 3 leading out of range
    task automatic test_small_graph();
        write_reg(ADDR_NODE_COUNT, 4);
        write_node(0, 1, 32'hFFFF_FFFF);
        write_node(1, 2, 32'h0000_0000);
        write_node(2, 0, 32'h1234_5678);
        write_node(3, fgks_pkg::NODE_W'(N_NODES - 1), 32'hA5A5_A5A5);
        write_node(fgks_pkg::NODE_W'(N_NODES - 1), fgks_pkg::NODE_W'(N_NODES - 1),
                   32'h5A5A_5A5A);
        query_node(0);
        write_reg(ADDR_STEP_COUNT, 1);
        query_node(3);
        query_node(2);
        write_reg(ADDR_STEP_COUNT, STEP_MASK);
        query_node(0);
        query_node(3);
        // Bits above the step field are dropped
        write_reg(ADDR_STEP_COUNT, 64'hF000_0000_0000_0005);
        query_node(1);
        write_reg(ADDR_STEP_COUNT, 64'h1 << (fgks_pkg::STEP_W - 1));
        query_node(1);
        // A write between queries forces another rebuild
        write_node(2, 3, 32'hFFFF_0000);
        query_node(0);
        // Upper bits dropped; node 3 falls out of range
        write_reg(ADDR_NODE_COUNT, {{(fgks_pkg::APB_DW-fgks_pkg::NCOUNT_W){1'b1}}, 11'd3});
        query_node(0);
        query_node(3);
    endtask

    // Groups of writes then queries, with config changes and noise between
    task automatic test_random_traffic();
        int unsigned nc;
        int unsigned roll;
        int unsigned n_wr;
        int unsigned n_q;
        int          phase_end;
        logic [63:0] steps_next;
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 69;
                end
                1:
                begin
                    send_idle_pct = 69;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_end = beats_sent + RANDOM_BEATS / 3;
            while (beats_sent < phase_end)
            begin
                // Keep node counts small so rebuilds stay cheap
                if ($urandom_range(99) < 30)
                begin
                    roll = $urandom_range(99);
                    if (roll < 5)
                        write_reg(ADDR_NODE_COUNT, 0);
                    else if (roll < 80)
                        write_reg(ADDR_NODE_COUNT, $urandom_range(12, 1));
                    else if (roll < 95)
                        write_reg(ADDR_NODE_COUNT, $urandom_range(40, 13));
                    else
                        write_reg(ADDR_NODE_COUNT, $urandom_range(96, 41));
                end
                if ($urandom_range(99) < 60)
                begin
                    roll = $urandom_range(99);
                    if (roll < 20)
                        steps_next = $urandom_range(15);
                    else if (roll < 45)
                        steps_next = {$urandom, $urandom} & STEP_MASK;
                    else if (roll < 60)
                        steps_next = STEP_MASK;
                    else if (roll < 75)
                        steps_next = 64'h1 << $urandom_range(fgks_pkg::STEP_W - 1);
                    else
                        steps_next = {$urandom, $urandom};
                    write_reg(ADDR_STEP_COUNT, steps_next);
                end
                else if ($urandom_range(99) < 15)
                    drain_results();

                fill_unwritten(85);
                nc   = live_nodes();
                n_wr = $urandom_range(4);
                n_q  = $urandom_range(10, 3);
                if (nc <= 12 && $urandom_range(99) < 20)
                begin
                    // Interleave writes and queries so most queries rebuild
                    repeat (n_wr + n_q)
                    begin
                        if ($urandom_range(1))
                            write_node(pick_node(nc, 80), pick_node(nc, 85), $urandom);
                        else
                            query_node(pick_node(nc, 85));
                    end
                end
                else
                begin
                    repeat (n_wr) write_node(pick_node(nc, 80), pick_node(nc, 85), $urandom);
                    repeat (n_q) query_node(pick_node(nc, 85));
                end
            end
        end
    endtask

    // Whole node range in use, then a node count past the table size
    task automatic test_full_graph();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(ADDR_NODE_COUNT, fgks_pkg::APB_DW'(N_NODES));
        fill_unwritten(100);
        write_reg(ADDR_STEP_COUNT, {$urandom, $urandom} & STEP_MASK);
        repeat (6) query_node(pick_node(N_NODES, 100));
        write_reg(ADDR_NODE_COUNT, NCOUNT_MAX);
        write_reg(ADDR_STEP_COUNT, STEP_MASK);
        repeat (6) query_node(pick_node(N_NODES, 100));
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_no_nodes();
        test_small_graph();
        test_random_traffic();
        test_full_graph();

        drain_results();
        if (mismatches == 0 && ends_due.size() == 0)
            $display("functional_graph_kth_successor: match");
        else
            $display("functional_graph_kth_successor: mismatch");
        $finish;
    end

endmodule
